[rtl/i2cm_pkg.sv]
`default_nettype none

package i2cm_pkg;

  // largest transaction length in data bytes
  localparam int MaxBytes = 4;
  // counters that must hold the byte count itself
  localparam int CntW = $clog2(MaxBytes + 1);
  // write buffer index
  localparam int WbufIdxW = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_START_WR = 2'd1,
    CMD_START_RD = 2'd2,
    CMD_LOAD     = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEVICE_ADDRESS  = 1'd0,
    CFG_TICKS_PER_DELAY = 1'd1
  } cfg_idx_e;

  // bus sequencer phases; each phase other than idle lasts one delay unit
  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_SA1  = 5'd1,
    PH_SA2  = 5'd2,
    PH_SB1  = 5'd3,
    PH_SB2  = 5'd4,
    PH_TXS  = 5'd5,
    PH_TXH1 = 5'd6,
    PH_TXH2 = 5'd7,
    PH_TXL  = 5'd8,
    PH_AR1  = 5'd9,
    PH_AR2  = 5'd10,
    PH_AH1  = 5'd11,
    PH_AH2  = 5'd12,
    PH_RL1  = 5'd13,
    PH_RL2  = 5'd14,
    PH_RH1  = 5'd15,
    PH_RH2  = 5'd16,
    PH_ML1  = 5'd17,
    PH_ML2  = 5'd18,
    PH_MH1  = 5'd19,
    PH_MH2  = 5'd20,
    PH_ST1  = 5'd21,
    PH_ST2  = 5'd22,
    PH_NS1  = 5'd23,
    PH_NS2  = 5'd24
  } phase_e;

  typedef enum logic [2:0] {
    SD_LOW,
    SD_HIGH,
    SD_BIT,
    SD_REL,
    SD_ACK
  } sda_mode_e;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] ticks_per_delay;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_sample;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_driving;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
    logic       nack_error;
    logic       busy_res;
  } res_t;

  function automatic logic scl_of(phase_e ph);
    logic scl;
    case (ph)
      PH_IDLE, PH_SA1, PH_SA2, PH_SB1, PH_SB2: scl = 1'b1;
      PH_TXH1, PH_TXH2, PH_AH1, PH_AH2:        scl = 1'b1;
      PH_RH1, PH_RH2, PH_MH1, PH_MH2:          scl = 1'b1;
      default:                                 scl = 1'b0;
    endcase
    return scl;
  endfunction

  function automatic sda_mode_e sda_mode_of(phase_e ph);
    sda_mode_e mode;
    case (ph)
      PH_IDLE, PH_SA1, PH_SA2:                mode = SD_HIGH;
      PH_TXS, PH_TXH1, PH_TXH2, PH_TXL:       mode = SD_BIT;
      PH_AR1, PH_AR2, PH_AH1, PH_AH2:         mode = SD_REL;
      PH_RL1, PH_RL2, PH_RH1, PH_RH2:         mode = SD_REL;
      PH_ML1, PH_ML2, PH_MH1, PH_MH2:         mode = SD_ACK;
      default:                                mode = SD_LOW;
    endcase
    return mode;
  endfunction

endpackage

`default_nettype wire

[rtl/i2cm_if.sv]
`default_nettype none

interface i2cm_req_if import i2cm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [2:0] byte_count;
  logic [7:0] write_byte;
  logic       sda_sample;

  modport source (output valid, output cmd, output byte_count, output write_byte,
                  output sda_sample, input ready);
  modport sink (input valid, input cmd, input byte_count, input write_byte,
                input sda_sample, output ready);
endinterface

interface i2cm_res_if import i2cm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_driving;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       done_res;
  logic       nack_error;
  logic       busy_res;

  modport source (output valid, output scl_level, output sda_level, output sda_driving,
                  output read_byte, output read_valid, output done_res,
                  output nack_error, output busy_res, input ready);
  modport sink (input valid, input scl_level, input sda_level, input sda_driving,
                input read_byte, input read_valid, input done_res,
                input nack_error, input busy_res, output ready);
endinterface

`default_nettype wire

[rtl/i2cm_cfg.sv]
`default_nettype none

module i2cm_cfg import i2cm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEVICE_ADDRESS:  cfg_d.device_address  = cfg_data_i[6:0];
        CFG_TICKS_PER_DELAY: cfg_d.ticks_per_delay = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address  <= 7'd64;
      cfg_q.ticks_per_delay <= 8'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/i2cm_seq.sv]
`default_nettype none

module i2cm_seq import i2cm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  req_t      req_i,
  input  cfg_t      cfg_i,
  output res_t      res_o
);

  phase_e             phase_q, phase_d;
  logic [3:0]         bit_cnt_q, bit_cnt_d;
  logic [CntW-1:0]    byte_idx_q, byte_idx_d;
  logic [7:0]         shift_q, shift_d;
  logic [CntW-1:0]    load_cnt_q, load_cnt_d;
  logic [CntW-1:0]    xfer_len_q, xfer_len_d;
  logic               is_read_q, is_read_d;
  logic [7:0]         delay_q, delay_d;

  logic [7:0]         wbuf_q [MaxBytes];
  logic               wbuf_we;

  cmd_e               cmd;
  logic [7:0]         tpd;
  logic [8:0]         delay_inc;
  logic [3:0]         bit_inc;
  logic [CntW-1:0]    byte_inc;
  logic [7:0]         rx_shift;
  logic [CntW-1:0]    clamped_len;
  logic [CntW:0]      ack_idx;
  sda_mode_e          mode;

  logic               scl;
  logic               sda_lvl;
  logic               sda_drv;
  logic [7:0]         rx_byte;
  logic               rx_valid;
  logic               done;
  logic               nack;
  logic               busy;

  assign cmd       = cmd_e'(req_i.cmd);
  assign tpd       = (cfg_i.ticks_per_delay == 8'd0) ? 8'd1 : cfg_i.ticks_per_delay;
  assign delay_inc = {1'b0, delay_q} + 9'd1;
  assign bit_inc   = bit_cnt_q + 4'd1;
  assign byte_inc  = byte_idx_q + CntW'(1);
  assign rx_shift  = {shift_q[6:0], req_i.sda_sample};

  always_comb begin
    if (req_i.byte_count == 3'd0) begin
      clamped_len = CntW'(1);
    end else if (int'(req_i.byte_count) > MaxBytes) begin
      clamped_len = CntW'(MaxBytes);
    end else begin
      clamped_len = CntW'(req_i.byte_count);
    end
  end

  // next state
  always_comb begin
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    byte_idx_d = byte_idx_q;
    shift_d    = shift_q;
    load_cnt_d = load_cnt_q;
    xfer_len_d = xfer_len_q;
    is_read_d  = is_read_q;
    delay_d    = delay_q;
    wbuf_we    = 1'b0;
    rx_byte    = 8'd0;
    rx_valid   = 1'b0;
    done       = 1'b0;
    nack       = 1'b0;
    if (step_i) begin
      if (phase_q == PH_IDLE) begin
        case (cmd)
          CMD_START_WR, CMD_START_RD: begin
            xfer_len_d = clamped_len;
            is_read_d  = (cmd == CMD_START_RD);
            byte_idx_d = '0;
            bit_cnt_d  = 4'd0;
            shift_d    = 8'd0;
            load_cnt_d = '0;
            delay_d    = 8'd0;
            phase_d    = PH_SA1;
          end
          CMD_LOAD: begin
            if (int'(load_cnt_q) < MaxBytes) begin
              wbuf_we    = 1'b1;
              load_cnt_d = load_cnt_q + CntW'(1);
            end
          end
          default: ;
        endcase
      end else if (cmd == CMD_TICK) begin
        if (delay_inc >= {1'b0, tpd}) begin
          delay_d = 8'd0;
          case (phase_q)
            PH_SB2: begin
              shift_d   = {cfg_i.device_address, is_read_q};
              bit_cnt_d = 4'd0;
              phase_d   = PH_TXS;
            end
            PH_TXL: begin
              shift_d   = {shift_q[6:0], 1'b0};
              bit_cnt_d = bit_inc;
              phase_d   = (bit_inc >= 4'd8) ? PH_AR1 : PH_TXS;
            end
            PH_AH2: begin
              if (req_i.sda_sample) begin
                phase_d = PH_NS1;
              end else if (is_read_q) begin
                byte_idx_d = '0;
                bit_cnt_d  = 4'd0;
                shift_d    = 8'd0;
                phase_d    = PH_RL1;
              end else if (byte_idx_q < xfer_len_q && int'(byte_idx_q) < MaxBytes) begin
                shift_d    = wbuf_q[byte_idx_q[WbufIdxW-1:0]];
                byte_idx_d = byte_inc;
                bit_cnt_d  = 4'd0;
                phase_d    = PH_TXS;
              end else begin
                phase_d = PH_ST1;
              end
            end
            PH_RH2: begin
              shift_d   = rx_shift;
              bit_cnt_d = bit_inc;
              if (bit_inc >= 4'd8) begin
                rx_byte  = rx_shift;
                rx_valid = 1'b1;
                phase_d  = PH_ML1;
              end else begin
                phase_d = PH_RL1;
              end
            end
            PH_MH2: begin
              byte_idx_d = byte_inc;
              if (byte_inc >= xfer_len_q) begin
                phase_d = PH_ST1;
              end else begin
                bit_cnt_d = 4'd0;
                shift_d   = 8'd0;
                phase_d   = PH_RL1;
              end
            end
            PH_ST2: begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
            PH_NS2: begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              nack    = 1'b1;
            end
            default: phase_d = phase_e'(phase_q + 5'd1);
          endcase
        end else begin
          delay_d = delay_inc[7:0];
        end
      end
    end
  end

  // bus levels after the step
  assign mode    = sda_mode_of(phase_d);
  assign ack_idx = {1'b0, byte_idx_d} + (CntW+1)'(1);

  always_comb begin
    scl     = scl_of(phase_d);
    sda_drv = 1'b1;
    case (mode)
      SD_LOW:  sda_lvl = 1'b0;
      SD_HIGH: sda_lvl = 1'b1;
      SD_BIT:  sda_lvl = shift_d[7];
      SD_ACK:  sda_lvl = (ack_idx >= {1'b0, xfer_len_d});
      default: begin
        sda_lvl = 1'b1;
        sda_drv = 1'b0;
      end
    endcase
    busy = (phase_d != PH_IDLE);
  end

  assign res_o = '{scl_level:   scl,
                   sda_level:   sda_lvl,
                   sda_driving: sda_drv,
                   read_byte:   rx_byte,
                   read_valid:  rx_valid,
                   done_res:    done,
                   nack_error:  nack,
                   busy_res:    busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= 4'd0;
      byte_idx_q <= '0;
      shift_q    <= 8'd0;
      load_cnt_q <= '0;
      xfer_len_q <= '0;
      is_read_q  <= 1'b0;
      delay_q    <= 8'd0;
    end else begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      byte_idx_q <= byte_idx_d;
      shift_q    <= shift_d;
      load_cnt_q <= load_cnt_d;
      xfer_len_q <= xfer_len_d;
      is_read_q  <= is_read_d;
      delay_q    <= delay_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wbuf_we) begin
      wbuf_q[load_cnt_q[WbufIdxW-1:0]] <= req_i.write_byte;
    end
  end

  a_nack_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.nack_error |-> res_o.done_res)
    else $error("nack flagged without done");

  a_start_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_IDLE && (cmd == CMD_START_WR || cmd == CMD_START_RD)
    |=> phase_q == PH_SA1)
    else $error("start word did not open a transaction");

  a_hold_without_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(delay_q))
    else $error("sequencer moved without a word");

  a_read_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.read_valid |-> !res_o.done_res && res_o.busy_res)
    else $error("received byte outside a transaction");

endmodule

`default_nettype wire

[rtl/i2c_master_transaction.sv]
`default_nettype none

// I2C master transaction engine. Request words on req_i drive a bus sequencer:
// a tick word (cmd 0) moves the bus timing by one tick and carries the sampled
// SDA level, a load word (cmd 3) appends a byte to the 4-entry write buffer, and
// a start word (cmd 1 write, cmd 2 read) opens a transaction of byte_count
// bytes (0 counts as 1, above 4 as 4); load the write bytes before the start,
// since each start clears the load count. Every request word yields exactly one
// result word with the SCL/SDA levels to drive after that word, plus the
// received byte, done and nack flags. A NACK from the target ends the
// transaction with one stop and nack_error set alongside done_res. Timing is in
// delay units of ticks_per_delay tick words (0 acts as 1). Configuration writes
// are only allowed while the engine is idle and no words are in flight.
// Throughput is one word per clock while the result side is ready; each word
// passes the input register and then the result register, and the result
// register frees the input side whenever the result is taken in the same cycle.

module i2c_master_transaction import i2cm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  i2cm_req_if.sink                 req_i,
  i2cm_res_if.source               res_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;
  req_t req_q;
  logic in_valid_q, in_valid_d;
  res_t res_q, res_next;
  logic res_valid_q, res_valid_d;
  logic advance;
  logic step;
  logic req_take;

  // result register can take a new word when empty or being drained
  assign advance  = !res_valid_q || res_o.ready;
  assign step     = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;
  assign req_take = req_i.valid && req_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (req_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (advance) begin
      res_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // input register, payload only
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_q.cmd        <= req_i.cmd;
      req_q.byte_count <= req_i.byte_count;
      req_q.write_byte <= req_i.write_byte;
      req_q.sda_sample <= req_i.sda_sample;
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  i2cm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer state advances once per word as it moves into the result register
  i2cm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  assign res_o.valid       = res_valid_q;
  assign res_o.scl_level   = res_q.scl_level;
  assign res_o.sda_level   = res_q.sda_level;
  assign res_o.sda_driving = res_q.sda_driving;
  assign res_o.read_byte   = res_q.read_byte;
  assign res_o.read_valid  = res_q.read_valid;
  assign res_o.done_res    = res_q.done_res;
  assign res_o.nack_error  = res_q.nack_error;
  assign res_o.busy_res    = res_q.busy_res;

  // a word waiting in the input register stays while the result is stalled
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(req_q))
    else $error("input word lost under stall");

  // a stalled result is neither dropped nor overwritten
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_o.ready |=> res_valid_q && $stable(res_q))
    else $error("result word lost under stall");

  // each word that leaves the input register lands in the result register
  a_step_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> res_valid_q)
    else $error("word dropped between stages");

endmodule

`default_nettype wire

[dv/i2cm_bus_checker.sv]
`timescale 1ns / 1ps

module i2cm_bus_checker import i2cm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  i2cm_req_if                 req_i,
  i2cm_res_if                 res_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatch_cnt_o,
  output int                  pending_o,
  output logic                idle_o,
  output phase_e              phase_o,
  output int                  checked_o,
  output int                  done_cnt_o,
  output int                  nack_cnt_o,
  output int                  rx_cnt_o
);

  // shadow copy of the bus sequencer
  phase_e          ph;
  logic [3:0]      bit_cnt;
  logic [2:0]      byte_idx;
  logic [7:0]      shreg;
  logic [7:0]      wbuf [MaxBytes];
  logic [CntW-1:0] load_cnt;
  logic [CntW-1:0] xfer_len;
  logic            rd_xfer;
  logic [7:0]      dly_cnt;
  logic [6:0]      dev_addr;
  logic [7:0]      unit_ticks;

  res_t bus_result_q[$];
  int   mismatches;
  int   outstanding;
  int   checked;
  int   done_cnt;
  int   nack_cnt;
  int   rx_cnt;

  assign mismatch_cnt_o = mismatches;
  assign pending_o      = outstanding;
  assign idle_o         = (ph == PH_IDLE);
  assign phase_o        = ph;
  assign checked_o      = checked;
  assign done_cnt_o     = done_cnt;
  assign nack_cnt_o     = nack_cnt;
  assign rx_cnt_o       = rx_cnt;

  // apply one request word and work out the bus levels that follow it
  task automatic step_bus_engine(input req_t w, output res_t r);
    logic [2:0] n;
    logic [7:0] eff;
    sda_mode_e  mode;
    r = '0;
    if (ph == PH_IDLE) begin
      if (w.cmd == CMD_START_WR || w.cmd == CMD_START_RD) begin
        if (w.byte_count == 3'd0) n = 3'd1;
        else if (w.byte_count > MaxBytes) n = 3'(MaxBytes);
        else n = w.byte_count;
        xfer_len = CntW'(n);
        rd_xfer  = (w.cmd == CMD_START_RD);
        byte_idx = '0;
        bit_cnt  = '0;
        shreg    = '0;
        load_cnt = '0;
        dly_cnt  = '0;
        ph       = PH_SA1;
      end else if (w.cmd == CMD_LOAD && load_cnt < MaxBytes) begin
        wbuf[load_cnt[WbufIdxW-1:0]] = w.write_byte;
        load_cnt = load_cnt + 1'b1;
      end
    end else if (w.cmd == CMD_TICK) begin
      eff = (unit_ticks == 8'd0) ? 8'd1 : unit_ticks;
      dly_cnt = dly_cnt + 8'd1;
      if (dly_cnt >= eff) begin
        dly_cnt = '0;
        case (ph)
          PH_SB2: begin
            shreg   = {dev_addr, rd_xfer};
            bit_cnt = '0;
            ph      = PH_TXS;
          end
          PH_TXL: begin
            shreg   = {shreg[6:0], 1'b0};
            bit_cnt = bit_cnt + 4'd1;
            ph      = (bit_cnt >= 4'd8) ? PH_AR1 : PH_TXS;
          end
          PH_AH2: begin
            if (w.sda_sample) begin
              ph = PH_NS1;
            end else if (rd_xfer) begin
              byte_idx = '0;
              bit_cnt  = '0;
              shreg    = '0;
              ph       = PH_RL1;
            end else if (byte_idx < xfer_len && byte_idx < MaxBytes) begin
              shreg    = wbuf[byte_idx[WbufIdxW-1:0]];
              byte_idx = byte_idx + 3'd1;
              bit_cnt  = '0;
              ph       = PH_TXS;
            end else begin
              ph = PH_ST1;
            end
          end
          PH_RH2: begin
            shreg   = {shreg[6:0], w.sda_sample};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
              r.read_byte  = shreg;
              r.read_valid = 1'b1;
              ph           = PH_ML1;
            end else begin
              ph = PH_RL1;
            end
          end
          PH_MH2: begin
            byte_idx = byte_idx + 3'd1;
            if (byte_idx >= xfer_len) begin
              ph = PH_ST1;
            end else begin
              bit_cnt = '0;
              shreg   = '0;
              ph      = PH_RL1;
            end
          end
          PH_ST2: begin
            ph         = PH_IDLE;
            r.done_res = 1'b1;
          end
          PH_NS2: begin
            ph           = PH_IDLE;
            r.done_res   = 1'b1;
            r.nack_error = 1'b1;
          end
          default: ph = phase_e'(ph + 5'd1);
        endcase
      end
    end

    case (ph)
      PH_TXS, PH_TXL, PH_AR1, PH_AR2, PH_RL1, PH_RL2, PH_ML1, PH_ML2,
      PH_ST1, PH_ST2, PH_NS1, PH_NS2: r.scl_level = 1'b0;
      default:                        r.scl_level = 1'b1;
    endcase
    case (ph)
      PH_IDLE, PH_SA1, PH_SA2:          mode = SD_HIGH;
      PH_TXS, PH_TXH1, PH_TXH2, PH_TXL: mode = SD_BIT;
      PH_ML1, PH_ML2, PH_MH1, PH_MH2:   mode = SD_ACK;
      PH_AR1, PH_AR2, PH_AH1, PH_AH2,
      PH_RL1, PH_RL2, PH_RH1, PH_RH2:   mode = SD_REL;
      default:                          mode = SD_LOW;
    endcase
    r.sda_driving = (mode != SD_REL);
    case (mode)
      SD_LOW:  r.sda_level = 1'b0;
      SD_BIT:  r.sda_level = shreg[7];
      // nack after the last byte of a read
      SD_ACK:  r.sda_level = (int'(byte_idx) + 1 >= int'(xfer_len));
      // driven high, or released to the pull-up
      default: r.sda_level = 1'b1;
    endcase
    r.busy_res = (ph != PH_IDLE);
  endtask

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    res_t fresh;
    req_t word;
    if (!rst_ni) begin
      ph         = PH_IDLE;
      bit_cnt    = '0;
      byte_idx   = '0;
      shreg      = '0;
      load_cnt   = '0;
      xfer_len   = '0;
      rd_xfer    = 1'b0;
      dly_cnt    = '0;
      dev_addr   = 7'd64;
      unit_ticks = 8'd1;
      foreach (wbuf[k]) wbuf[k] = '0;
      bus_result_q.delete();
      mismatches  = 0;
      outstanding = 0;
      checked     = 0;
      done_cnt    = 0;
      nack_cnt    = 0;
      rx_cnt      = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_DEVICE_ADDRESS) dev_addr = cfg_data_i[6:0];
        else if (cfg_index_i == CFG_TICKS_PER_DELAY) unit_ticks = cfg_data_i;
      end
      if (res_i.valid && res_i.ready) begin
        if (bus_result_q.size() == 0) begin
          $error("result word with no request outstanding");
          mismatches++;
        end else begin
          want = bus_result_q.pop_front();
          check_field("scl_level", want.scl_level, res_i.scl_level);
          check_field("sda_level", want.sda_level, res_i.sda_level);
          check_field("sda_driving", want.sda_driving, res_i.sda_driving);
          check_field("read_byte", want.read_byte, res_i.read_byte);
          check_field("read_valid", want.read_valid, res_i.read_valid);
          check_field("done_res", want.done_res, res_i.done_res);
          check_field("nack_error", want.nack_error, res_i.nack_error);
          check_field("busy_res", want.busy_res, res_i.busy_res);
          checked++;
          if (want.done_res) done_cnt++;
          if (want.nack_error) nack_cnt++;
          if (want.read_valid) rx_cnt++;
        end
      end
      if (req_i.valid && req_i.ready) begin
        word = {req_i.cmd, req_i.byte_count, req_i.write_byte, req_i.sda_sample};
        step_bus_engine(word, fresh);
        bus_result_q.push_back(fresh);
      end
      outstanding = bus_result_q.size();
    end
  end

endmodule

[dv/tb_i2c_master_transaction.sv]
`timescale 1ns / 1ps

module tb_i2c_master_transaction;
  import i2cm_pkg::*;

  // generous bound, several times the longest run with the widest gaps and stalls
  localparam int CycleLimit = 200_000;
  // long receiver hold-off that backs the block up into its input
  localparam int LongHold = 300;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we;
  cfg_idx_e            cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  i2cm_req_if req_if ();
  i2cm_res_if res_if ();

  // checker view of the engine
  int     mismatches;
  int     pending;
  logic   eng_idle;
  phase_e eng_phase;
  int     checked;
  int     done_cnt;
  int     nack_cnt;
  int     rx_cnt;

  int words_sent;
  int cycles;
  // calm stretches with no idling on either side; hush forces both quiet
  bit tx_calm;
  bit rx_calm;
  bit hush;

  i2c_master_transaction dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  i2cm_bus_checker u_bus_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .res_i          (res_if),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .idle_o         (eng_idle),
    .phase_o        (eng_phase),
    .checked_o      (checked),
    .done_cnt_o     (done_cnt),
    .nack_cnt_o     (nack_cnt),
    .rx_cnt_o       (rx_cnt)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog
  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("i2c_master_transaction verification failed");
    $finish;
  end

  // one request word: random gap, then hold valid until the handshake
  task automatic put_word(input cmd_e cmd, input logic [2:0] cnt, input logic [7:0] wbyte,
                          input logic sda);
    int gap;
    if ($urandom_range(0, 47) == 0) tx_calm = !tx_calm;
    gap = (hush || tx_calm) ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.cmd        <= cmd;
    req_if.byte_count <= cnt;
    req_if.write_byte <= wbyte;
    req_if.sda_sample <= sda;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  // loads, a start, then tick words until the engine goes idle again.
  // nack_at picks which target ack (1 = address) is answered with a nack,
  // nack_pct adds random nacks, fill forces read data low (1) or high (2)
  task automatic run_transfer(input bit rd, input logic [2:0] cnt, input int nload,
                              input int nack_at, input int nack_pct, input int fill);
    int     ack_no;
    bit     ack_lvl;
    bit     sda;
    phase_e prev;
    ack_no  = 0;
    ack_lvl = 1'b0;
    prev    = PH_IDLE;
    repeat (nload) begin
      put_word(CMD_LOAD, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
    end
    put_word(rd ? CMD_START_RD : CMD_START_WR, cnt, 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
    while (!eng_idle) begin
      if ($urandom_range(0, 19) == 0) begin
        // start or load while busy: the engine must ignore it
        put_word(cmd_e'(2'($urandom_range(1, 3))), 3'($urandom_range(0, 7)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        if (eng_phase == PH_AH2) begin
          // hold one level over the whole ack window
          if (prev != PH_AH2) begin
            ack_no++;
            ack_lvl = (ack_no == nack_at) || (int'($urandom_range(0, 99)) < nack_pct);
          end
          sda = ack_lvl;
        end else if (fill == 1) begin
          sda = 1'b0;
        end else if (fill == 2) begin
          sda = 1'b1;
        end else begin
          sda = 1'($urandom_range(0, 1));
        end
        prev = eng_phase;
        put_word(CMD_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), sda);
      end
    end
  endtask

  // wait until every result word is back and the block has drained
  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic reconfigure(input logic [7:0] addr_val, input logic [7:0] ticks_val);
    settle();
    write_reg(CFG_DEVICE_ADDRESS, addr_val);
    write_reg(CFG_TICKS_PER_DELAY, ticks_val);
  endtask

  // mostly well-formed transfers with random content, some idle noise
  task automatic random_phase(input int budget);
    int         first;
    bit         rd;
    logic [2:0] cnt;
    int         need;
    int         nload;
    int         nack_at;
    int         fill;
    first = words_sent;
    while (words_sent - first < budget) begin
      if ($urandom_range(0, 5) == 0) begin
        // idle noise, a stray start or load among it
        put_word(cmd_e'(2'($urandom_range(0, 3))), 3'($urandom_range(0, 7)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      rd  = 1'($urandom_range(0, 1));
      cnt = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 2));
      need = (cnt == 3'd0) ? 1 : (cnt > MaxBytes) ? MaxBytes : int'(cnt);
      if (rd) nload = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2)) : 0;
      else if ($urandom_range(0, 9) == 0) nload = int'($urandom_range(0, 5));
      else nload = need + int'($urandom_range(0, 1));
      nack_at = ($urandom_range(0, 11) == 0) ? int'($urandom_range(1, 3)) : 0;
      fill = ($urandom_range(0, 7) < 6) ? 0 : int'($urandom_range(1, 2));
      run_transfer(rd, cnt, nload, nack_at, 2, fill);
    end
  endtask

  // result side: random ready gaps, calm stretches and two long hold-offs
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    res_if.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 47) == 0) rx_calm = !rx_calm;
      if (taken == 200 || taken == 900) hold = LongHold;
      else if (hush || rx_calm) hold = 0;
      else hold = int'($urandom_range(0, 10));
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    req_if.valid      = 1'b0;
    req_if.cmd        = CMD_TICK;
    req_if.byte_count = '0;
    req_if.write_byte = '0;
    req_if.sda_sample = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_DEVICE_ADDRESS;
    cfg_data   = '0;
    words_sent = 0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    hush       = 1'b0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // fill all four buffer entries with corner bytes; the fifth load finds it full
    put_word(CMD_LOAD, 3'd0, 8'h00, 1'b0);
    put_word(CMD_LOAD, 3'd7, 8'hFF, 1'b1);
    put_word(CMD_LOAD, 3'd1, 8'h80, 1'b0);
    put_word(CMD_LOAD, 3'd4, 8'h01, 1'b1);
    put_word(CMD_LOAD, 3'd2, 8'h5A, 1'b0);
    // tick while idle does nothing
    put_word(CMD_TICK, 3'd0, 8'h00, 1'b1);

    // reset settings: address 64, one tick per unit
    run_transfer(1'b0, 3'd4, 0, 0, 0, 0);
    // count zero acts as one; read byte of all ones
    run_transfer(1'b1, 3'd0, 0, 0, 0, 2);
    // count above range is clamped; nack on the first data byte
    run_transfer(1'b0, 3'd7, 4, 2, 0, 0);
    // read refused at the address
    run_transfer(1'b1, 3'd2, 0, 1, 0, 0);

    // address 0 and zero ticks per unit, which acts as one
    reconfigure(8'h00, 8'h00);
    run_transfer(1'b0, 3'd1, 1, 0, 0, 0);
    // address 127 (upper data bit set), two ticks per unit, read of zeros
    reconfigure(8'hFF, 8'd2);
    run_transfer(1'b1, 3'd2, 0, 0, 0, 1);

    // random part over several settings
    reconfigure(8'($urandom_range(0, 127)), 8'd1);
    random_phase(60);
    reconfigure(8'h80, 8'd1);
    random_phase(60);
    reconfigure(8'($urandom_range(0, 127)), 8'd2);
    random_phase(60);
    reconfigure(8'h7F, 8'd3);
    random_phase(60);

    settle();
    $display("sent %0d request words, checked %0d result words", words_sent, checked);
    $display("%0d transfers closed, %0d on a target nack, %0d bytes received",
             done_cnt, nack_cnt, rx_cnt);
    if (mismatches == 0 && pending == 0) begin
      $display("i2c_master_transaction verification clean");
    end else begin
      $display("i2c_master_transaction verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_cfg.sv
rtl/i2cm_seq.sv
rtl/i2c_master_transaction.sv
dv/i2cm_bus_checker.sv
dv/tb_i2c_master_transaction.sv
